// ===== rtl/bpcfm_pkg.sv =====
// Package for the buffer pool clock frame manager.
// Holds request and status codes, controller state enum and command/status structs.
`timescale 1ns / 1ps
package bpcfm_pkg;

    localparam int FRAMES_DEF       = 16;
    localparam int PAGE_ID_BITS_DEF = 32;
    localparam int PIN_BITS_DEF     = 8;

    localparam logic [1:0] REQ_GET   = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_UNPIN = 2'd2;
    localparam logic [1:0] REQ_FLUSH = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFRAME = 2'd1;
    localparam logic [1:0] ST_UNPIN   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_FLUSH,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic lookup;     // do tag match / free search
        logic scan_step;  // examine one frame under the clock hand
        logic flush_step; // examine one frame of the flush walk
        logic out_take;   // result register was taken
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_flush;     // flush request with at least one frame to write back
        logic need_scan;    // no hit and no free frame
        logic scan_done;    // victim found or two turns spent
        logic flush_end;    // flush walk at last frame
        logic out_valid;
    } stat_t;

endpackage

// ===== rtl/bpcfm_ctrl.sv =====
// Controller state machine for the buffer pool clock frame manager.
// Depends on bpcfm_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps
module bpcfm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_stall,
    input  bpcfm_pkg::stat_t    stat,
    output logic                in_stall,
    output bpcfm_pkg::cmd_t     cmd
);

    bpcfm_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bpcfm_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpcfm_pkg::S_IDLE:
                if (in_valid)
                    state_next = bpcfm_pkg::S_LOOKUP;
            bpcfm_pkg::S_LOOKUP:
                if (stat.is_flush)
                    state_next = bpcfm_pkg::S_FLUSH;
                else if (stat.need_scan)
                    state_next = bpcfm_pkg::S_SCAN;
                else
                    state_next = bpcfm_pkg::S_OUT;
            bpcfm_pkg::S_SCAN:
                if (stat.scan_done)
                    state_next = bpcfm_pkg::S_OUT;
            bpcfm_pkg::S_FLUSH:
                if ((!stat.out_valid || !out_stall) && stat.flush_end)
                    state_next = bpcfm_pkg::S_OUT;
            bpcfm_pkg::S_OUT:
                if (!stat.out_valid || !out_stall)
                    state_next = bpcfm_pkg::S_IDLE;
            default:
                state_next = bpcfm_pkg::S_IDLE;
        endcase
    end

    // Output decode.
    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        cmd.out_take = stat.out_valid && !out_stall;
        unique case (state_reg)
            bpcfm_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            bpcfm_pkg::S_LOOKUP: cmd.lookup = 1'b1;
            bpcfm_pkg::S_SCAN:   cmd.scan_step = 1'b1;
            bpcfm_pkg::S_FLUSH:  cmd.flush_step = !stat.out_valid || !out_stall;
            default: ;
        endcase
    end

    // Only in idle can an item be taken.
    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == bpcfm_pkg::S_IDLE) else $error("stall low outside idle");
    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == bpcfm_pkg::S_LOOKUP) else $error("load not followed by lookup");
    a_scan_from: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == bpcfm_pkg::S_SCAN) |-> $past(state_reg) == bpcfm_pkg::S_LOOKUP)
        else $error("scan entered from wrong state");

endmodule

// ===== rtl/bpcfm_dp.sv =====
// Datapath of the buffer pool clock frame manager: frame table, clock hand,
// page counter, result register. Depends on bpcfm_pkg.
`timescale 1ns / 1ps
module bpcfm_dp #(
    parameter int FRAMES       = bpcfm_pkg::FRAMES_DEF,
    parameter int PAGE_ID_BITS = bpcfm_pkg::PAGE_ID_BITS_DEF,
    parameter int PIN_BITS     = bpcfm_pkg::PIN_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bpcfm_pkg::cmd_t         cmd,
    output bpcfm_pkg::stat_t        stat,
    input  logic                    cfg_we,
    input  logic [31:0]             cfg_wdata,
    input  logic [1:0]              req_type,
    input  logic [31:0]             page_id,
    input  logic [3:0]              frame_index,
    input  logic                    mark_dirty,
    output logic                    out_valid,
    output logic [1:0]              status,
    output logic [3:0]              frame_slot,
    output logic [31:0]             placed_page_id,
    output logic                    hit,
    output logic                    fetch_needed,
    output logic                    write_back,
    output logic [31:0]             write_back_page_id,
    output logic                    last
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int SW = FW + 2;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
    localparam logic [FW-1:0] FLAST = FW'(FRAMES - 1);

    // Frame table.
    logic [FRAMES-1:0]       valid_reg, dirty_reg, ref_reg;
    logic [PAGE_ID_BITS-1:0] tag_reg [FRAMES];
    logic [PIN_BITS-1:0]     pin_reg [FRAMES];

    logic [FW-1:0]           hand_reg, pos_reg, fptr_reg;
    logic [SW-1:0]           steps_reg;
    logic [PAGE_ID_BITS-1:0] cnt_reg;

    // Captured request.
    logic [1:0]              rq_reg;
    logic [PAGE_ID_BITS-1:0] pid_reg;
    logic [3:0]              fi_reg;
    logic                    md_reg;
    logic [4:0]              nflush_reg;

    // Output register.
    logic                    ov_reg;
    logic [1:0]              o_st_reg;
    logic [3:0]              o_fs_reg;
    logic [31:0]             o_pp_reg, o_wb_id_reg;
    logic                    o_hit_reg, o_fetch_reg, o_wb_reg, o_last_reg;

    // Tag match and free frame search.
    logic              hit_any, free_any;
    logic [FW-1:0]     hit_idx, free_idx;
    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == pid_reg)
            begin
                hit_any = 1'b1;
                hit_idx = FW'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = FW'(i);
            end
        end
    end

    // Flush candidates: valid, unpinned and dirty frames. The walk needs to
    // know whether another candidate lies ahead to mark the final transfer.
    logic [FRAMES-1:0] cand;
    logic              cand_any, cand_after;
    always_comb
    begin
        cand_after = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            cand[i] = valid_reg[i] && pin_reg[i] == '0 && dirty_reg[i];
            if (i > int'(fptr_reg) && cand[i])
                cand_after = 1'b1;
        end
    end
    assign cand_any = |cand;

    logic                    is_ga, unpin_ok, fi_range;
    logic [FW-1:0]           fi_w;
    logic [PAGE_ID_BITS-1:0] new_id;
    logic                    victim, f_emit;
    logic                    hit_any_eff;
    assign is_ga    = rq_reg == bpcfm_pkg::REQ_GET || rq_reg == bpcfm_pkg::REQ_ALLOC;
    assign new_id   = (rq_reg == bpcfm_pkg::REQ_GET) ? pid_reg : cnt_reg;
    assign fi_range = 32'(fi_reg) < FRAMES;
    assign fi_w     = FW'(fi_reg);
    assign unpin_ok = fi_range && valid_reg[fi_w] && pin_reg[fi_w] != '0;
    assign victim   = pin_reg[pos_reg] == '0 && !ref_reg[pos_reg];
    assign f_emit   = cand[fptr_reg] && nflush_reg != 5'd16;
    assign hit_any_eff = hit_any && rq_reg == bpcfm_pkg::REQ_GET;

    assign stat.is_flush     = rq_reg == bpcfm_pkg::REQ_FLUSH && cand_any;
    assign stat.need_scan    = is_ga && !hit_any_eff && !free_any;
    assign stat.scan_done    = victim || steps_reg == SW'(2 * FRAMES - 1);
    assign stat.flush_end    = fptr_reg == FLAST;
    assign stat.out_valid    = ov_reg;

    function automatic logic [31:0] lo32(input logic [PAGE_ID_BITS-1:0] v);
        logic [PAGE_ID_BITS+31:0] e;
        e = {32'd0, v};
        return e[31:0];
    endfunction

    // Frame table, counters and output register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            dirty_reg   <= '0;
            ref_reg     <= '0;
            for (int i = 0; i < FRAMES; i++)
                pin_reg[i] <= '0;
            hand_reg    <= '0;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
            pos_reg     <= '0;
            fptr_reg    <= '0;
            steps_reg   <= '0;
            nflush_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                cnt_reg <= PAGE_ID_BITS'(cfg_wdata);
            // A flush result loaded in the same cycle keeps the register full.
            if (cmd.out_take && !(cmd.flush_step && f_emit))
                ov_reg <= 1'b0;
            if (cmd.load)
            begin
                pos_reg     <= hand_reg;
                fptr_reg    <= '0;
                steps_reg   <= '0;
                nflush_reg  <= '0;
            end
            // Lookup cycle: resolves hit, free fill, unpin and an empty flush.
            if (cmd.lookup)
            begin
                if (is_ga && hit_any_eff)
                begin
                    if (pin_reg[hit_idx] != PIN_MAX)
                        pin_reg[hit_idx] <= pin_reg[hit_idx] + 1'b1;
                    ref_reg[hit_idx] <= 1'b1;
                    ov_reg <= 1'b1;
                    o_st_reg <= bpcfm_pkg::ST_OK; o_fs_reg <= 4'(hit_idx);
                    o_pp_reg <= lo32(pid_reg); o_hit_reg <= 1'b1; o_fetch_reg <= 1'b0;
                    o_wb_reg <= 1'b0; o_wb_id_reg <= '0; o_last_reg <= 1'b1;
                end
                else if (is_ga && free_any)
                begin
                    valid_reg[free_idx] <= 1'b1;
                    tag_reg[free_idx]   <= new_id;
                    pin_reg[free_idx]   <= PIN_BITS'(1);
                    dirty_reg[free_idx] <= 1'b0;
                    ref_reg[free_idx]   <= 1'b0;
                    if (rq_reg == bpcfm_pkg::REQ_ALLOC)
                        cnt_reg <= cnt_reg + 1'b1;
                    ov_reg <= 1'b1;
                    o_st_reg <= bpcfm_pkg::ST_OK; o_fs_reg <= 4'(free_idx);
                    o_pp_reg <= lo32(new_id); o_hit_reg <= 1'b0;
                    o_fetch_reg <= rq_reg == bpcfm_pkg::REQ_GET;
                    o_wb_reg <= 1'b0; o_wb_id_reg <= '0; o_last_reg <= 1'b1;
                end
                else if (rq_reg == bpcfm_pkg::REQ_UNPIN)
                begin
                    ov_reg <= 1'b1;
                    o_fs_reg <= fi_reg; o_hit_reg <= 1'b0; o_fetch_reg <= 1'b0;
                    o_wb_reg <= 1'b0; o_wb_id_reg <= '0; o_last_reg <= 1'b1;
                    if (unpin_ok)
                    begin
                        pin_reg[fi_w] <= pin_reg[fi_w] - 1'b1;
                        if (md_reg)
                            dirty_reg[fi_w] <= 1'b1;
                        o_st_reg <= bpcfm_pkg::ST_OK;
                        o_pp_reg <= lo32(tag_reg[fi_w]);
                    end
                    else
                    begin
                        o_st_reg <= bpcfm_pkg::ST_UNPIN;
                        o_pp_reg <= (fi_range && valid_reg[fi_w]) ? lo32(tag_reg[fi_w]) : '0;
                    end
                end
                else if (rq_reg == bpcfm_pkg::REQ_FLUSH && !cand_any)
                begin
                    // Nothing to write back: a single empty result closes the flush.
                    ov_reg <= 1'b1;
                    o_st_reg <= bpcfm_pkg::ST_OK; o_fs_reg <= '0;
                    o_pp_reg <= '0; o_hit_reg <= 1'b0; o_fetch_reg <= 1'b0;
                    o_wb_reg <= 1'b0; o_wb_id_reg <= '0; o_last_reg <= 1'b1;
                end
            end
            // Clock scan: one frame per cycle.
            if (cmd.scan_step)
            begin
                steps_reg <= steps_reg + 1'b1;
                pos_reg   <= (pos_reg == FLAST) ? '0 : pos_reg + 1'b1;
                if (victim)
                begin
                    hand_reg <= (pos_reg == FLAST) ? '0 : pos_reg + 1'b1;
                    tag_reg[pos_reg]   <= new_id;
                    pin_reg[pos_reg]   <= PIN_BITS'(1);
                    dirty_reg[pos_reg] <= 1'b0;
                    if (rq_reg == bpcfm_pkg::REQ_ALLOC)
                        cnt_reg <= cnt_reg + 1'b1;
                    ov_reg <= 1'b1;
                    o_st_reg <= bpcfm_pkg::ST_OK; o_fs_reg <= 4'(pos_reg);
                    o_pp_reg <= lo32(new_id); o_hit_reg <= 1'b0;
                    o_fetch_reg <= rq_reg == bpcfm_pkg::REQ_GET;
                    o_wb_reg <= dirty_reg[pos_reg];
                    o_wb_id_reg <= dirty_reg[pos_reg] ? lo32(tag_reg[pos_reg]) : '0;
                    o_last_reg <= 1'b1;
                end
                else
                begin
                    if (pin_reg[pos_reg] == '0)
                        ref_reg[pos_reg] <= 1'b0;
                    if (stat.scan_done)
                    begin
                        ov_reg <= 1'b1;
                        o_st_reg <= bpcfm_pkg::ST_NOFRAME; o_fs_reg <= '0;
                        o_pp_reg <= '0; o_hit_reg <= 1'b0; o_fetch_reg <= 1'b0;
                        o_wb_reg <= 1'b0; o_wb_id_reg <= '0; o_last_reg <= 1'b1;
                    end
                end
            end
            // Flush walk: one frame per cycle while no result is stalled. The transfer
            // with no candidate ahead of it, or the sixteenth of the request, carries last.
            if (cmd.flush_step)
            begin
                fptr_reg <= fptr_reg + 1'b1;
                if (f_emit)
                begin
                    dirty_reg[fptr_reg] <= 1'b0;
                    nflush_reg  <= nflush_reg + 1'b1;
                    ov_reg <= 1'b1;
                    o_st_reg <= bpcfm_pkg::ST_OK; o_fs_reg <= 4'(fptr_reg);
                    o_pp_reg <= lo32(tag_reg[fptr_reg]); o_hit_reg <= 1'b0;
                    o_fetch_reg <= 1'b0; o_wb_reg <= 1'b1;
                    o_wb_id_reg <= lo32(tag_reg[fptr_reg]);
                    o_last_reg <= !cand_after || nflush_reg == 5'd15;
                end
            end
        end
    end

    // Capture request fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rq_reg  <= req_type;
            pid_reg <= PAGE_ID_BITS'(page_id);
            fi_reg  <= frame_index;
            md_reg  <= mark_dirty;
        end
    end

    assign out_valid          = ov_reg;
    assign status             = o_st_reg;
    assign frame_slot         = o_fs_reg;
    assign placed_page_id     = o_pp_reg;
    assign hit                = o_hit_reg;
    assign fetch_needed       = o_fetch_reg;
    assign write_back         = o_wb_reg;
    assign write_back_page_id = o_wb_id_reg;
    assign last               = o_last_reg;

    a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hand_reg) < FRAMES) else $error("clock hand out of range");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> 32'(steps_reg) < 2 * FRAMES) else $error("scan ran too long");
    a_fill_pin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step && victim |=> pin_reg[$past(pos_reg)] == PIN_BITS'(1))
        else $error("victim not pinned");

endmodule

// ===== rtl/buffer_pool_clock_frame_manager.sv =====
// Top level of the buffer pool clock frame manager.
// Joins bpcfm_ctrl and bpcfm_dp; depends on bpcfm_pkg.
//
// Usage: one input channel (in_valid/in_stall plus request fields) and one
// result channel (out_valid/out_stall plus result fields). A request is
// taken only while the block is idle. For get hits, free-frame fills,
// unpins and a flush with nothing to write back, the request is captured,
// the lookup state loads the result register, the result transfers from
// the output state, and the block then returns to idle for the next
// request. A clock scan examines one frame per cycle, up to two turns of
// the table. A flush with work walks every frame, one per cycle, and
// sends one transfer per dirty unpinned frame, at most sixteen; the last
// of them carries last. When the receiver stalls, the held result waits
// and the walk pauses. The single configuration register loads the page
// counter when start_page_id_we is high. Reset clears the table's control
// bits, the clock hand and the page counter.
`timescale 1ns / 1ps
module buffer_pool_clock_frame_manager #(
    parameter int FRAMES       = bpcfm_pkg::FRAMES_DEF,
    parameter int PAGE_ID_BITS = bpcfm_pkg::PAGE_ID_BITS_DEF,
    parameter int PIN_BITS     = bpcfm_pkg::PIN_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start_page_id_we,
    input  logic [31:0] start_page_id,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] page_id,
    input  logic [3:0]  frame_index,
    input  logic        mark_dirty,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  frame_slot,
    output logic [31:0] placed_page_id,
    output logic        hit,
    output logic        fetch_needed,
    output logic        write_back,
    output logic [31:0] write_back_page_id,
    output logic        last
);

    bpcfm_pkg::cmd_t  cmd;
    bpcfm_pkg::stat_t stat;

    bpcfm_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .out_stall, .stat, .in_stall, .cmd
    );

    bpcfm_dp #(
        .FRAMES(FRAMES), .PAGE_ID_BITS(PAGE_ID_BITS), .PIN_BITS(PIN_BITS)
    ) u_dp (
        .clk, .rst_n, .cmd, .stat,
        .cfg_we(start_page_id_we), .cfg_wdata(start_page_id),
        .req_type, .page_id, .frame_index, .mark_dirty,
        .out_valid, .status, .frame_slot, .placed_page_id, .hit,
        .fetch_needed, .write_back, .write_back_page_id, .last
    );

endmodule
